### src/fca_pkg.sv
package fca_pkg;

  localparam int BLOCK_W = 10;
  localparam int COUNT_W = 11;

  typedef enum logic [1:0] {
    OP_START  = 2'd0,
    OP_APPEND = 2'd1,
    OP_FREE   = 2'd2,
    OP_COUNT  = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_TAIL_RD,
    ST_TAIL_CHK,
    ST_SCAN,
    ST_MARK,
    ST_LINK_TAIL,
    ST_WALK_RD,
    ST_WALK_CHK,
    ST_DONE
  } state_t;

  typedef struct packed {
    op_t                operation;
    logic [BLOCK_W-1:0] block;
  } in_t;

  typedef struct packed {
    logic [BLOCK_W-1:0] new_block;
    logic               ok;
    logic [COUNT_W-1:0] free_count;
  } out_t;

endpackage

### src/fca_link_ram.sv
module fca_link_ram #(
  parameter int AW = 10,
  parameter int LW = 11
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [LW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [LW-1:0] rdata
);

  logic [LW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### src/fca_ctrl.sv
module fca_ctrl #(
  parameter int BLOCKS = 1024,
  parameter int AW = 10,
  parameter int LW = 11
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  fca_pkg::in_t  req,
  output logic          res_valid,
  input  logic          res_take,
  output fca_pkg::out_t res,
  output logic          ram_we,
  output logic [AW-1:0] ram_waddr,
  output logic [LW-1:0] ram_wdata,
  output logic [AW-1:0] ram_raddr,
  input  logic [LW-1:0] ram_rdata
);

  import fca_pkg::*;

  localparam int IW = ((AW > BLOCK_W) ? AW : BLOCK_W) + 1;
  localparam logic [LW-1:0] LINK_END = '1;

  state_t        state, state_next;
  op_t           op, op_next;
  logic [AW-1:0] tail, tail_next;
  logic [AW-1:0] cur, cur_next;
  logic [AW-1:0] chk, chk_next;
  logic [AW-1:0] pick, pick_next;
  logic [AW:0]   scan_addr, scan_addr_next;
  logic [AW:0]   free_total, free_total_next;
  logic          pending, pending_next;
  logic          ok, ok_next;
  logic          in_range;

  assign in_range = IW'(req.block) < IW'(BLOCKS);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      scan_addr  <= '0;
      free_total <= (AW+1)'(BLOCKS);
    end else begin
      state      <= state_next;
      scan_addr  <= scan_addr_next;
      free_total <= free_total_next;
    end
  end

  always_ff @(posedge clk) begin
    op      <= op_next;
    tail    <= tail_next;
    cur     <= cur_next;
    chk     <= chk_next;
    pick    <= pick_next;
    pending <= pending_next;
    ok      <= ok_next;
  end

  always_comb begin
    state_next      = state;
    op_next         = op;
    tail_next       = tail;
    cur_next        = cur;
    chk_next        = chk;
    pick_next       = pick;
    scan_addr_next  = scan_addr;
    free_total_next = free_total;
    pending_next    = pending;
    ok_next         = ok;
    req_ready       = 1'b0;
    res_valid       = 1'b0;
    ram_we          = 1'b0;
    ram_waddr       = cur;
    ram_wdata       = '0;
    ram_raddr       = cur;
    case (state)
      ST_CLEAR: begin
        ram_we         = 1'b1;
        ram_waddr      = AW'(scan_addr);
        scan_addr_next = scan_addr + 1'b1;
        if (scan_addr == (AW+1)'(BLOCKS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          op_next        = req.operation;
          tail_next      = AW'(req.block);
          cur_next       = AW'(req.block);
          pick_next      = '0;
          ok_next        = 1'b1;
          pending_next   = 1'b0;
          scan_addr_next = '0;
          case (req.operation)
            OP_START: state_next = ST_SCAN;
            OP_APPEND: begin
              if (in_range) begin
                state_next = ST_TAIL_RD;
              end else begin
                ok_next    = 1'b0;
                state_next = ST_DONE;
              end
            end
            OP_FREE: state_next = in_range ? ST_WALK_RD : ST_DONE;
            default: state_next = ST_DONE;
          endcase
        end
      end
      ST_TAIL_RD: begin
        ram_raddr  = tail;
        state_next = ST_TAIL_CHK;
      end
      ST_TAIL_CHK: begin
        if (ram_rdata == '0) begin
          ok_next    = 1'b0;
          state_next = ST_DONE;
        end else begin
          scan_addr_next = (AW+1)'(1);
          state_next     = ST_SCAN;
        end
      end
      ST_SCAN: begin
        ram_raddr = AW'(scan_addr);
        if (pending && ram_rdata == '0) begin
          pick_next  = chk;
          state_next = ST_MARK;
        end else if (scan_addr == (AW+1)'(BLOCKS)) begin
          ok_next    = 1'b0;
          state_next = ST_DONE;
        end else begin
          chk_next       = AW'(scan_addr);
          pending_next   = 1'b1;
          scan_addr_next = scan_addr + 1'b1;
        end
      end
      ST_MARK: begin
        ram_we          = 1'b1;
        ram_waddr       = pick;
        ram_wdata       = LINK_END;
        free_total_next = free_total - 1'b1;
        state_next      = (op == OP_APPEND) ? ST_LINK_TAIL : ST_DONE;
      end
      ST_LINK_TAIL: begin
        ram_we     = 1'b1;
        ram_waddr  = tail;
        ram_wdata  = LW'(pick);
        state_next = ST_DONE;
      end
      ST_WALK_RD: begin
        ram_raddr  = cur;
        state_next = ST_WALK_CHK;
      end
      ST_WALK_CHK: begin
        if (ram_rdata == '0) begin
          state_next = ST_DONE;
        end else begin
          ram_we          = 1'b1;
          ram_waddr       = cur;
          free_total_next = free_total + 1'b1;
          if (ram_rdata >= LW'(BLOCKS)) begin
            state_next = ST_DONE;
          end else begin
            cur_next   = AW'(ram_rdata);
            state_next = ST_WALK_RD;
          end
        end
      end
      ST_DONE: begin
        res_valid = 1'b1;
        if (res_take) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign res.new_block  = ok ? BLOCK_W'(pick) : '0;
  assign res.ok         = ok;
  assign res.free_count = COUNT_W'(free_total);

endmodule

### src/fat_chain_allocator.sv
// Chain allocator over a file allocation table of BLOCKS link entries held in a
// table memory with one write and one registered read per cycle. After reset the
// table is cleared one entry per cycle, so req_ready stays low until it is clear.
// Then one transaction is worked at a time. Count only returns the free count.
// Start and append are set by the lowest-free search, which reads one table entry
// per cycle. Free releases one block per walk step and stops at the chain end or
// at a free entry, so a free head releases nothing. A finished result sits in
// an output register while the next request is taken.
module fat_chain_allocator #(
  parameter int BLOCKS = 1024
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  fca_pkg::in_t  req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output fca_pkg::out_t rsp
);

  import fca_pkg::*;

  localparam int AW = $clog2(BLOCKS);
  localparam int LW = AW + 1;

  logic          res_valid;
  logic          res_take;
  out_t          res;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [LW-1:0] ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [LW-1:0] ram_rdata;

  assign res_take = !rsp_valid || rsp_ready;

  fca_ctrl #(
    .BLOCKS(BLOCKS),
    .AW    (AW),
    .LW    (LW)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req),
    .res_valid(res_valid),
    .res_take (res_take),
    .res      (res),
    .ram_we   (ram_we),
    .ram_waddr(ram_waddr),
    .ram_wdata(ram_wdata),
    .ram_raddr(ram_raddr),
    .ram_rdata(ram_rdata)
  );

  fca_link_ram #(
    .AW(AW),
    .LW(LW)
  ) u_link_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_take) begin
      rsp_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take && res_valid) begin
      rsp <= res;
    end
  end

  a_fail_no_block: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.ok |-> rsp.new_block == '0)
    else $error("failed allocation returned a block");

  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while busy");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    res_valid && rsp_valid && !rsp_ready |=> res_valid)
    else $error("result dropped while output full");

endmodule

### tb/fat_chain_allocator_test.sv
`timescale 1ns / 1ps

module fat_chain_allocator_test;
  import fca_pkg::*;

  localparam int BLOCKS = 1024;
  localparam logic [COUNT_W-1:0] LINK_END = COUNT_W'(2 * BLOCKS - 1);
  localparam int CYCLE_LIMIT = 8_000_000;
  localparam int RANDOM_PER_PHASE = 140;
  localparam int SEND_IDLE [4] = '{0, 78, 0, 37};
  localparam int RSP_STALL [4] = '{0, 0, 78, 37};

  typedef enum {PICK_LIVE, PICK_HEAD, PICK_TAIL} pick_t;

  typedef struct packed {
    in_t  cmd;
    logic known;
    out_t want;
  } row_t;

  // want is only meaningful where known is set
  localparam row_t DIRECTED [19] = '{
    '{'{OP_COUNT,  10'd0},    1'b1, '{10'd0, 1'b1, 11'd1024}},
    '{'{OP_COUNT,  10'd1023}, 1'b1, '{10'd0, 1'b1, 11'd1024}},
    '{'{OP_FREE,   10'd0},    1'b1, '{10'd0, 1'b1, 11'd1024}},
    '{'{OP_FREE,   10'd1023}, 1'b1, '{10'd0, 1'b1, 11'd1024}},
    '{'{OP_APPEND, 10'd0},    1'b1, '{10'd0, 1'b0, 11'd1024}},
    '{'{OP_APPEND, 10'd1023}, 1'b1, '{10'd0, 1'b0, 11'd1024}},
    '{'{OP_START,  10'd1023}, 1'b1, '{10'd0, 1'b1, 11'd1023}},
    '{'{OP_APPEND, 10'd0},    1'b1, '{10'd1, 1'b1, 11'd1022}},
    '{'{OP_APPEND, 10'd1},    1'b1, '{10'd2, 1'b1, 11'd1021}},
    '{'{OP_START,  10'd0},    1'b1, '{10'd3, 1'b1, 11'd1020}},
    '{'{OP_APPEND, 10'd0},    1'b0, '0},
    '{'{OP_FREE,   10'd1},    1'b0, '0},
    '{'{OP_START,  10'd682},  1'b0, '0},
    '{'{OP_APPEND, 10'd3},    1'b0, '0},
    '{'{OP_FREE,   10'd4},    1'b0, '0},
    '{'{OP_FREE,   10'd0},    1'b0, '0},
    '{'{OP_FREE,   10'd3},    1'b0, '0},
    '{'{OP_FREE,   10'd1},    1'b0, '0},
    '{'{OP_COUNT,  10'd341},  1'b1, '{10'd0, 1'b1, 11'd1024}}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  in_t  req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  out_t rsp;

  logic [COUNT_W-1:0] fat_link [BLOCKS];
  int                 fat_free;

  out_t alloc_results_q [$];
  out_t rsp_want;
  int   fault_count = 0;
  int   send_idle_pct = 0;
  int   rsp_stall_pct = 0;
  int   cycle_count = 0;

  fat_chain_allocator #(.BLOCKS(BLOCKS)) dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp(rsp)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic out_t fat_apply(in_t item);
    out_t r;
    int pick;
    int cur;
    int steps;
    logic [COUNT_W-1:0] nxt;
    logic walking;
    r = '0;
    r.ok = 1'b1;
    case (item.operation)
      OP_START, OP_APPEND: begin
        pick = BLOCKS;
        if (item.operation == OP_START || fat_link[item.block] != '0) begin
          pick = (item.operation == OP_APPEND) ? 1 : 0;
          while (pick < BLOCKS && fat_link[BLOCK_W'(pick)] != '0) pick++;
        end
        if (pick < BLOCKS) begin
          if (item.operation == OP_APPEND) fat_link[item.block] = COUNT_W'(pick);
          fat_link[BLOCK_W'(pick)] = LINK_END;
          if (fat_free > 0) fat_free--;
          r.new_block = BLOCK_W'(pick);
        end else begin
          r.ok = 1'b0;
        end
      end
      OP_FREE: begin
        cur = int'(item.block);
        steps = 0;
        walking = 1'b1;
        while (walking && cur < BLOCKS && steps < BLOCKS) begin
          nxt = fat_link[BLOCK_W'(cur)];
          if (nxt == '0) begin
            walking = 1'b0;
          end else begin
            fat_link[BLOCK_W'(cur)] = '0;
            fat_free++;
            steps++;
            if (nxt == LINK_END) walking = 1'b0;
            else cur = int'(nxt);
          end
        end
      end
      default: ;
    endcase
    r.free_count = COUNT_W'(fat_free);
    return r;
  endfunction

  function automatic logic [BLOCK_W-1:0] pick_block(pick_t kind);
    int cand [$];
    bit pointed [BLOCKS];
    foreach (pointed[k]) pointed[k] = 1'b0;
    for (int k = 0; k < BLOCKS; k++) begin
      if (fat_link[BLOCK_W'(k)] != '0 && fat_link[BLOCK_W'(k)] != LINK_END)
        pointed[fat_link[BLOCK_W'(k)][BLOCK_W-1:0]] = 1'b1;
    end
    for (int k = 0; k < BLOCKS; k++) begin
      if (fat_link[BLOCK_W'(k)] != '0) begin
        case (kind)
          PICK_LIVE: cand.push_back(k);
          PICK_HEAD: if (!pointed[BLOCK_W'(k)]) cand.push_back(k);
          PICK_TAIL: if (fat_link[BLOCK_W'(k)] == LINK_END) cand.push_back(k);
          default: ;
        endcase
      end
    end
    if (cand.size() == 0) return BLOCK_W'($urandom_range(0, BLOCKS - 1));
    return BLOCK_W'(cand[$urandom_range(0, cand.size() - 1)]);
  endfunction

  task automatic send_item(input op_t op, input logic [BLOCK_W-1:0] blk, input logic known,
                           input out_t want);
    in_t  item;
    out_t model_out;
    item.operation = op;
    item.block = blk;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= item;
    do @(posedge clk); while (!req_ready);
    model_out = fat_apply(item);
    alloc_results_q.push_back(known ? want : model_out);
  endtask

  task automatic issue_random_item();
    int roll;
    roll = $urandom_range(0, 99);
    // keep occupancy low so free-block searches stay short
    if (BLOCKS - fat_free > 120 && roll < 60)
      send_item(OP_FREE, pick_block(PICK_HEAD), 1'b0, '0);
    else if (roll < 15) send_item(OP_START, BLOCK_W'($urandom), 1'b0, '0);
    else if (roll < 48) send_item(OP_APPEND, pick_block(PICK_TAIL), 1'b0, '0);
    else if (roll < 56) send_item(OP_APPEND, pick_block(PICK_LIVE), 1'b0, '0);
    else if (roll < 62) send_item(OP_APPEND, BLOCK_W'($urandom), 1'b0, '0);
    else if (roll < 78) send_item(OP_FREE, pick_block(PICK_HEAD), 1'b0, '0);
    else if (roll < 83) send_item(OP_FREE, pick_block(PICK_LIVE), 1'b0, '0);
    else if (roll < 88) send_item(OP_FREE, BLOCK_W'($urandom), 1'b0, '0);
    else send_item(OP_COUNT, BLOCK_W'($urandom), 1'b0, '0);
  endtask

  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) begin
      if (alloc_results_q.size() == 0) begin
        fault_count++;
        if (fault_count <= 10)
          $display("unexpected transaction: new_block=%0d ok=%0d free_count=%0d",
                   rsp.new_block, rsp.ok, rsp.free_count);
      end else begin
        rsp_want = alloc_results_q.pop_front();
        if (rsp.new_block !== rsp_want.new_block || rsp.ok !== rsp_want.ok ||
            rsp.free_count !== rsp_want.free_count) begin
          fault_count++;
          if (fault_count <= 10)
            $display("mismatch: want new_block=%0d ok=%0d free_count=%0d, got %0d %0d %0d",
                     rsp_want.new_block, rsp_want.ok, rsp_want.free_count,
                     rsp.new_block, rsp.ok, rsp.free_count);
        end
      end
    end
    rsp_ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    foreach (fat_link[k]) fat_link[k] = '0;
    fat_free = BLOCKS;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (DIRECTED[i])
      send_item(DIRECTED[i].cmd.operation, DIRECTED[i].cmd.block, DIRECTED[i].known,
                DIRECTED[i].want);

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = SEND_IDLE[ph];
      rsp_stall_pct = RSP_STALL[ph];
      repeat (RANDOM_PER_PHASE) issue_random_item();
    end

    req_valid <= 1'b0;
    while (alloc_results_q.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
    if (fault_count == 0 && alloc_results_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
